[hdl/tlf_pkg.sv]
// ----------------------------------------------------------------------------
// Timed lamp with fade: shared package
// Types, codes and small arithmetic helpers used by the lamp controller.
// ----------------------------------------------------------------------------
package tlf_pkg;

  // Default timer constants, overridable on the top level.
  localparam int unsigned MS_PER_MINUTE_DEF = 60000;
  localparam int unsigned SHORT_HOLD_MS_DEF = 10000;

  // Field widths.
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned MINUTES_W = 12;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned EVENT_W   = 2;

  // Divider for the fade ratio: 255 * 32-bit numerator over a 32-bit span.
  localparam int unsigned DIV_NUM_W = TIME_W + LEVEL_W;
  localparam int unsigned DIV_Q_W   = LEVEL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W);

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_WARM_RED   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WARM_GREEN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WARM_BLUE  = 2'd2;

  localparam logic [LEVEL_W-1:0] WARM_RED_RST   = 8'd255;
  localparam logic [LEVEL_W-1:0] WARM_GREEN_RST = 8'd180;
  localparam logic [LEVEL_W-1:0] WARM_BLUE_RST  = 8'd60;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 8'd255;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_PHASE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_EXTEND    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_RESTART   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RED_TEST  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_MANUAL    = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_LAMP_OFF  = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_FADE      = 3'd7;

  // Lamp phases.
  localparam logic [PHASE_W-1:0] PH_OFF        = 3'd0;
  localparam logic [PHASE_W-1:0] PH_POST_OPEN  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_POST_CLOSE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LAST       = 3'd4;

  // Phase-ended events.
  localparam logic [EVENT_W-1:0] EV_NONE       = 2'd0;
  localparam logic [EVENT_W-1:0] EV_POST_OPEN  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_POST_CLOSE = 2'd2;

  // Colour channel indexes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } warm_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FADE,
    ST_DIV,
    ST_SCALE,
    ST_PUSH
  } state_t;

  // Exact floor(x / 255) for any product of two 8-bit values.
  function automatic logic [LEVEL_W-1:0] div255(input logic [2*LEVEL_W-1:0] x);
    logic [2*LEVEL_W:0] t;
    t = 17'(x) + 17'(x[2*LEVEL_W-1:LEVEL_W]) + 17'd1;
    return t[2*LEVEL_W-1:LEVEL_W];
  endfunction

endpackage

[hdl/tlf_cfg.sv]
// ----------------------------------------------------------------------------
// Timed lamp with fade: configuration registers
// APB-style register file holding the warm-white colour levels.
// ----------------------------------------------------------------------------
module tlf_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tlf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tlf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tlf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output tlf_pkg::warm_t                     warm
);

  tlf_pkg::warm_t                    warm_r;
  tlf_pkg::warm_t                    warm_nxt;
  logic [tlf_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[tlf_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign warm    = warm_r;

  always_comb begin
    warm_nxt = warm_r;
    if (wr_en) begin
      case (reg_idx)
        tlf_pkg::REG_WARM_RED:   warm_nxt.red   = pwdata[tlf_pkg::LEVEL_W-1:0];
        tlf_pkg::REG_WARM_GREEN: warm_nxt.green = pwdata[tlf_pkg::LEVEL_W-1:0];
        tlf_pkg::REG_WARM_BLUE:  warm_nxt.blue  = pwdata[tlf_pkg::LEVEL_W-1:0];
        default:                 warm_nxt       = warm_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tlf_pkg::REG_WARM_RED:   prdata = 32'(warm_r.red);
      tlf_pkg::REG_WARM_GREEN: prdata = 32'(warm_r.green);
      tlf_pkg::REG_WARM_BLUE:  prdata = 32'(warm_r.blue);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r.red   <= tlf_pkg::WARM_RED_RST;
      warm_r.green <= tlf_pkg::WARM_GREEN_RST;
      warm_r.blue  <= tlf_pkg::WARM_BLUE_RST;
    end else begin
      warm_r <= warm_nxt;
    end
  end

endmodule

[hdl/tlf_div.sv]
// ----------------------------------------------------------------------------
// Timed lamp with fade: fade ratio divider
// Restoring divider, one quotient bit per cycle, for a quotient below 256.
// ----------------------------------------------------------------------------
module tlf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [tlf_pkg::DIV_NUM_W-1:0]     num,
  input  logic [tlf_pkg::TIME_W-1:0]        den,
  output logic                              done,
  output logic [tlf_pkg::DIV_Q_W-1:0]       quot
);

  logic [tlf_pkg::DIV_NUM_W-1:0]  rem_r, rem_nxt;
  logic [tlf_pkg::DIV_NUM_W-1:0]  dsh_r, dsh_nxt;
  logic [tlf_pkg::DIV_Q_W-1:0]    quot_r, quot_nxt;
  logic [tlf_pkg::DIV_CNT_W-1:0]  step_r, step_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic                           fits;

  // The caller guarantees num < 256 * den, so eight quotient bits suffice.
  assign fits = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = tlf_pkg::DIV_NUM_W'(den) << (tlf_pkg::DIV_Q_W - 1);
      quot_nxt = '0;
      step_nxt = tlf_pkg::DIV_CNT_W'(tlf_pkg::DIV_Q_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      quot_nxt = {quot_r[tlf_pkg::DIV_Q_W-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[hdl/timed_lamp_with_fade_core.sv]
// ----------------------------------------------------------------------------
// Timed lamp with fade: top level
// Lamp phase timer, red test and manual hold, relay and colour control with
// a linear fade, run by a small sequencer around a shared divider and a
// shared 8x8 multiplier.
// ----------------------------------------------------------------------------
// Sequence: commands pass EXEC and PUSH; plain ticks also pass FADE, and a
//   tick that scales the colours waits in DIV for the divider (skipped for
//   a zero span), then runs SCALE once per channel on the multiplier.
// Throughput: one item at a time; the next item is taken in the cycle after
//   the result is handed to the output register, even if it still waits.
// Reset: synchronous, active low; lamp state, timers and colours clear,
//   warm colour registers return to 255/180/60.
module timed_lamp_with_fade_core #(
  parameter int unsigned MS_PER_MINUTE = tlf_pkg::MS_PER_MINUTE_DEF,
  parameter int unsigned SHORT_HOLD_MS = tlf_pkg::SHORT_HOLD_MS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tlf_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [tlf_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [tlf_pkg::PHASE_W-1:0]       in_phase_value,
  input  logic [tlf_pkg::MINUTES_W-1:0]     in_minutes,
  input  logic                              in_flag,
  input  logic [tlf_pkg::TIME_W-1:0]        in_fade_start,
  input  logic [tlf_pkg::TIME_W-1:0]        in_fade_end,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_relay,
  output logic [tlf_pkg::LEVEL_W-1:0]       out_red_level,
  output logic [tlf_pkg::LEVEL_W-1:0]       out_green_level,
  output logic [tlf_pkg::LEVEL_W-1:0]       out_blue_level,
  output logic [tlf_pkg::PHASE_W-1:0]       out_phase_now,
  output logic [tlf_pkg::EVENT_W-1:0]       out_ended_event,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tlf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tlf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tlf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned HOLD_PROD_W = tlf_pkg::MINUTES_W + tlf_pkg::TIME_W;

  tlf_pkg::state_t state_r, state_nxt;
  tlf_pkg::warm_t  warm;

  // Captured item.
  logic [tlf_pkg::OPCODE_W-1:0]   op_r;
  logic [tlf_pkg::TIME_W-1:0]     now_r;
  logic [tlf_pkg::PHASE_W-1:0]    phase_val_r;
  logic [tlf_pkg::MINUTES_W-1:0]  minutes_r;
  logic                           flag_r;
  logic [tlf_pkg::TIME_W-1:0]     fstart_r;
  logic [tlf_pkg::TIME_W-1:0]     fend_r;

  // Lamp state.
  logic [tlf_pkg::PHASE_W-1:0]    phase_r, phase_nxt;
  logic [tlf_pkg::TIME_W-1:0]     deadline_r, deadline_nxt;
  logic                           lamp_active_r, lamp_active_nxt;
  logic                           manual_r, manual_nxt;
  logic                           red_test_r, red_test_nxt;
  logic                           fade_active_r, fade_active_nxt;
  logic [tlf_pkg::TIME_W-1:0]     fbegin_r, fbegin_nxt;
  logic [tlf_pkg::TIME_W-1:0]     ffinish_r, ffinish_nxt;
  logic                           relay_r, relay_nxt;
  logic [tlf_pkg::LEVEL_W-1:0]    colour_r [3];
  logic [tlf_pkg::LEVEL_W-1:0]    colour_nxt [3];
  logic [tlf_pkg::EVENT_W-1:0]    ended_r, ended_nxt;
  logic [tlf_pkg::LEVEL_W-1:0]    bright_r, bright_nxt;
  logic [1:0]                     ch_r, ch_nxt;

  // Result register.
  logic                           out_valid_r, out_valid_nxt;
  logic                           o_relay_r, o_relay_nxt;
  logic [tlf_pkg::LEVEL_W-1:0]    o_red_r, o_red_nxt;
  logic [tlf_pkg::LEVEL_W-1:0]    o_green_r, o_green_nxt;
  logic [tlf_pkg::LEVEL_W-1:0]    o_blue_r, o_blue_nxt;
  logic [tlf_pkg::PHASE_W-1:0]    o_phase_r, o_phase_nxt;
  logic [tlf_pkg::EVENT_W-1:0]    o_event_r, o_event_nxt;

  // Datapath.
  logic                           in_take;
  logic                           out_free;
  logic [HOLD_PROD_W-1:0]         hold_prod;
  logic [tlf_pkg::TIME_W-1:0]     hold_len;
  logic [tlf_pkg::TIME_W-1:0]     span;
  logic [tlf_pkg::TIME_W-1:0]     remain;
  logic [tlf_pkg::DIV_NUM_W-1:0]  div_num;
  logic                           fade_run;
  logic                           in_window;
  logic                           div_start;
  logic                           div_done;
  logic [tlf_pkg::DIV_Q_W-1:0]    div_quot;
  logic [tlf_pkg::LEVEL_W-1:0]    warm_sel;
  logic [2*tlf_pkg::LEVEL_W-1:0]  scale_prod;

  tlf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .warm    (warm)
  );

  tlf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_stall = (state_r != tlf_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign hold_prod = HOLD_PROD_W'(minutes_r) * HOLD_PROD_W'(MS_PER_MINUTE);
  assign hold_len  = (minutes_r == '0) ? tlf_pkg::TIME_W'(SHORT_HOLD_MS)
                                       : hold_prod[tlf_pkg::TIME_W-1:0];

  assign span      = ffinish_r - fbegin_r;
  assign remain    = ffinish_r - now_r;
  // 255 * remain, as (remain << 8) - remain.
  assign div_num   = {remain, 8'd0} - tlf_pkg::DIV_NUM_W'(remain);
  assign fade_run  = fade_active_r && lamp_active_r;
  assign in_window = (now_r >= fbegin_r) && (now_r <= ffinish_r);
  assign div_start = (state_r == tlf_pkg::ST_FADE) && fade_run && in_window
                     && (span != '0);

  always_comb begin
    case (ch_r)
      tlf_pkg::CH_RED:   warm_sel = warm.red;
      tlf_pkg::CH_GREEN: warm_sel = warm.green;
      default:           warm_sel = warm.blue;
    endcase
  end

  assign scale_prod = warm_sel * bright_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlf_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = tlf_pkg::ST_EXEC;
        end
      end
      tlf_pkg::ST_EXEC: begin
        state_nxt = (op_r == tlf_pkg::OP_TICK) ? tlf_pkg::ST_FADE : tlf_pkg::ST_PUSH;
      end
      tlf_pkg::ST_FADE: begin
        if (fade_run && in_window) begin
          state_nxt = (span == '0) ? tlf_pkg::ST_SCALE : tlf_pkg::ST_DIV;
        end else begin
          state_nxt = tlf_pkg::ST_PUSH;
        end
      end
      tlf_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = tlf_pkg::ST_SCALE;
        end
      end
      tlf_pkg::ST_SCALE: begin
        if (ch_r == tlf_pkg::CH_BLUE) begin
          state_nxt = tlf_pkg::ST_PUSH;
        end
      end
      tlf_pkg::ST_PUSH: begin
        if (out_free) begin
          state_nxt = tlf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    phase_nxt       = phase_r;
    deadline_nxt    = deadline_r;
    lamp_active_nxt = lamp_active_r;
    manual_nxt      = manual_r;
    red_test_nxt    = red_test_r;
    fade_active_nxt = fade_active_r;
    fbegin_nxt      = fbegin_r;
    ffinish_nxt     = ffinish_r;
    relay_nxt       = relay_r;
    colour_nxt      = colour_r;
    ended_nxt       = ended_r;
    bright_nxt      = bright_r;
    ch_nxt          = ch_r;
    out_valid_nxt   = out_valid_r && out_stall;
    o_relay_nxt     = o_relay_r;
    o_red_nxt       = o_red_r;
    o_green_nxt     = o_green_r;
    o_blue_nxt      = o_blue_r;
    o_phase_nxt     = o_phase_r;
    o_event_nxt     = o_event_r;

    case (state_r)
      tlf_pkg::ST_EXEC: begin
        ended_nxt = tlf_pkg::EV_NONE;
        case (op_r)
          tlf_pkg::OP_TICK: begin
            if (!red_test_r && !manual_r) begin
              if (phase_r == tlf_pkg::PH_OFF) begin
                if (lamp_active_r) begin
                  relay_nxt       = 1'b0;
                  colour_nxt      = '{default: '0};
                  fade_active_nxt = 1'b0;
                  lamp_active_nxt = 1'b0;
                end
              end else begin
                if (!lamp_active_r) begin
                  relay_nxt       = 1'b1;
                  colour_nxt[0]   = warm.red;
                  colour_nxt[1]   = warm.green;
                  colour_nxt[2]   = warm.blue;
                  lamp_active_nxt = 1'b1;
                end
                if (now_r >= deadline_r) begin
                  if (phase_r == tlf_pkg::PH_POST_OPEN) begin
                    ended_nxt = tlf_pkg::EV_POST_OPEN;
                  end else if (phase_r == tlf_pkg::PH_POST_CLOSE) begin
                    ended_nxt = tlf_pkg::EV_POST_CLOSE;
                  end
                  phase_nxt = tlf_pkg::PH_OFF;
                end
              end
            end
          end
          tlf_pkg::OP_SET_PHASE: begin
            if (phase_val_r <= tlf_pkg::PH_LAST) begin
              phase_nxt = phase_val_r;
            end
          end
          tlf_pkg::OP_EXTEND: begin
            if (deadline_r > now_r) begin
              deadline_nxt = deadline_r + hold_len;
            end else begin
              deadline_nxt = now_r + hold_len;
            end
          end
          tlf_pkg::OP_RESTART: begin
            deadline_nxt = now_r + hold_len;
          end
          tlf_pkg::OP_RED_TEST: begin
            red_test_nxt  = flag_r;
            colour_nxt    = '{default: '0};
            colour_nxt[0] = flag_r ? tlf_pkg::LEVEL_FULL : '0;
          end
          tlf_pkg::OP_MANUAL: begin
            manual_nxt = flag_r;
          end
          tlf_pkg::OP_LAMP_OFF: begin
            relay_nxt       = 1'b0;
            colour_nxt      = '{default: '0};
            fade_active_nxt = 1'b0;
            phase_nxt       = tlf_pkg::PH_OFF;
          end
          default: begin
            fade_active_nxt = 1'b1;
            fbegin_nxt      = fstart_r;
            ffinish_nxt     = fend_r;
          end
        endcase
      end
      tlf_pkg::ST_FADE: begin
        ch_nxt     = tlf_pkg::CH_RED;
        bright_nxt = tlf_pkg::LEVEL_FULL;
        if (fade_run && (now_r > ffinish_r)) begin
          fade_active_nxt = 1'b0;
        end
      end
      tlf_pkg::ST_DIV: begin
        if (div_done) begin
          bright_nxt = div_quot;
        end
      end
      tlf_pkg::ST_SCALE: begin
        colour_nxt[ch_r] = tlf_pkg::div255(scale_prod);
        ch_nxt           = ch_r + 1'b1;
      end
      tlf_pkg::ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_relay_nxt   = relay_r;
          o_red_nxt     = colour_r[0];
          o_green_nxt   = colour_r[1];
          o_blue_nxt    = colour_r[2];
          o_phase_nxt   = phase_r;
          o_event_nxt   = ended_r;
        end
      end
      default: begin
        ch_nxt = ch_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tlf_pkg::ST_IDLE;
      phase_r       <= tlf_pkg::PH_OFF;
      deadline_r    <= '0;
      lamp_active_r <= 1'b0;
      manual_r      <= 1'b0;
      red_test_r    <= 1'b0;
      fade_active_r <= 1'b0;
      fbegin_r      <= '0;
      ffinish_r     <= '0;
      relay_r       <= 1'b0;
      colour_r      <= '{default: '0};
      ended_r       <= tlf_pkg::EV_NONE;
      ch_r          <= tlf_pkg::CH_RED;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      deadline_r    <= deadline_nxt;
      lamp_active_r <= lamp_active_nxt;
      manual_r      <= manual_nxt;
      red_test_r    <= red_test_nxt;
      fade_active_r <= fade_active_nxt;
      fbegin_r      <= fbegin_nxt;
      ffinish_r     <= ffinish_nxt;
      relay_r       <= relay_nxt;
      colour_r      <= colour_nxt;
      ended_r       <= ended_nxt;
      ch_r          <= ch_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    bright_r  <= bright_nxt;
    o_relay_r <= o_relay_nxt;
    o_red_r   <= o_red_nxt;
    o_green_r <= o_green_nxt;
    o_blue_r  <= o_blue_nxt;
    o_phase_r <= o_phase_nxt;
    o_event_r <= o_event_nxt;
    if (in_take) begin
      op_r        <= in_opcode;
      now_r       <= in_now_ms;
      phase_val_r <= in_phase_value;
      minutes_r   <= in_minutes;
      flag_r      <= in_flag;
      fstart_r    <= in_fade_start;
      fend_r      <= in_fade_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_relay       = o_relay_r;
  assign out_red_level   = o_red_r;
  assign out_green_level = o_green_r;
  assign out_blue_level  = o_blue_r;
  assign out_phase_now   = o_phase_r;
  assign out_ended_event = o_event_r;

  // An accepted item keeps the input side closed for at least the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input taken while an item is in progress");

  // A new result only comes out of the hand-off state.
  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == tlf_pkg::ST_PUSH))
    else $error("result appeared outside the hand-off state");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == tlf_pkg::ST_DIV))
    else $error("divider finished outside its wait state");

  // While a result is valid, the reported phase never exceeds the last defined phase.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase_now <= tlf_pkg::PH_LAST))
    else $error("reported phase out of range");

endmodule
